[rtl/pmm_pkg.sv]
// ----------------------------------------------------------------------------
// pmm_pkg
// shared constants, operation and status codes of the paged memory manager
// ----------------------------------------------------------------------------
`default_nettype none

package pmm_pkg;

  localparam int MAIN_PAGES_DEF     = 64;
  localparam int SWAP_PAGES_DEF     = 128;
  localparam int PAGE_WORDS_DEF     = 16;
  localparam int MAX_PIDS_DEF       = 16;
  localparam int MAX_PROC_PAGES_DEF = 16;

  localparam int KIND_W     = 4;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 104;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int STATUS_W   = 4;
  localparam int WORD_W     = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_MAIN_PAGES = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SWAP_PAGES = 1'd1;
  localparam logic [6:0] MAIN_IN_USE_RST = 7'd64;
  localparam logic [7:0] SWAP_IN_USE_RST = 8'd128;

  localparam logic [3:0] K_LOAD     = 4'd0;
  localparam logic [3:0] K_ACTIVATE = 4'd1;
  localparam logic [3:0] K_STORE    = 4'd2;
  localparam logic [3:0] K_ADD      = 4'd3;
  localparam logic [3:0] K_SUB      = 4'd4;
  localparam logic [3:0] K_READ     = 4'd5;
  localparam logic [3:0] K_KILL     = 4'd6;
  localparam logic [3:0] K_SWAPOUT  = 4'd7;
  localparam logic [3:0] K_SWAPIN   = 4'd8;
  localparam logic [3:0] K_PHYSREAD = 4'd9;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_LOAD_MAIN   = 4'd1;
  localparam logic [3:0] ST_LOAD_SWAP   = 4'd2;
  localparam logic [3:0] ST_FULL        = 4'd3;
  localparam logic [3:0] ST_NO_PROC     = 4'd4;
  localparam logic [3:0] ST_LRU_BIG     = 4'd5;
  localparam logic [3:0] ST_LRU_SWAP    = 4'd6;
  localparam logic [3:0] ST_LRU_SHORT   = 4'd7;
  localparam logic [3:0] ST_BAD_ADDR    = 4'd8;
  localparam logic [3:0] ST_ALREADY     = 4'd9;
  localparam logic [3:0] ST_KILL_MAIN   = 4'd10;
  localparam logic [3:0] ST_KILL_SWAP   = 4'd11;
  localparam logic [3:0] ST_NO_SWAP     = 4'd12;
  localparam logic [3:0] ST_PIDS_OUT    = 4'd13;
  localparam logic [3:0] ST_PHYS_BOUNDS = 4'd14;

  localparam logic [1:0] AT_NONE = 2'd0;
  localparam logic [1:0] AT_MAIN = 2'd1;
  localparam logic [1:0] AT_SWAP = 2'd2;

endpackage

`default_nettype wire

[rtl/pmm_ram.sv]
// ----------------------------------------------------------------------------
// pmm_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
`default_nettype none

module pmm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/pmm_alu.sv]
// ----------------------------------------------------------------------------
// pmm_alu
// shared add/subtract unit for word arithmetic and page offset reduction
// ----------------------------------------------------------------------------
`default_nettype none

module pmm_alu (
  input  wire logic        sub,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  assign y = sub ? (a - b) : (a + b);

endmodule

`default_nettype wire

[rtl/paged_memory_manager_lru_swap.sv]
// ----------------------------------------------------------------------------
// paged_memory_manager_lru_swap
// paged main/swap word memory with process page tables and lru eviction
// ----------------------------------------------------------------------------
// After reset and after every configuration write the block runs a clearing
// pass that zeroes both word memories; in_tready stays low meanwhile.
// One transaction is worked at a time by a sequencer around a shared adder.
// A store, read, add or sub is slowed by the one-page-a-cycle offset
// reduction, and a read, add or sub also by the single read port of main
// memory. Loads and moves scan the frame bitmaps one frame a cycle, kills
// walk the page table of the process, and a move copies a page word by word,
// a read then a write, through the single ports of the word memories. A
// finished result waits in the output register while the next transaction
// is taken.
`default_nettype none

module paged_memory_manager_lru_swap #(
  parameter int MAIN_PAGES     = pmm_pkg::MAIN_PAGES_DEF,
  parameter int SWAP_PAGES     = pmm_pkg::SWAP_PAGES_DEF,
  parameter int PAGE_WORDS     = pmm_pkg::PAGE_WORDS_DEF,
  parameter int MAX_PIDS       = pmm_pkg::MAX_PIDS_DEF,
  parameter int MAX_PROC_PAGES = pmm_pkg::MAX_PROC_PAGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // pid, size_pages, addr_a, addr_b, addr_c, value
  input  wire logic [pmm_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind
  input  wire logic [pmm_pkg::KIND_W-1:0]        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // status, assigned_pid, value_a, value_b, value_c
  output logic      [pmm_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [pmm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [pmm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import pmm_pkg::*;

  localparam int MAIN_WORDS = MAIN_PAGES * PAGE_WORDS;
  localparam int SWAP_WORDS = SWAP_PAGES * PAGE_WORDS;
  localparam int MWA   = $clog2(MAIN_WORDS);
  localparam int SWA   = $clog2(SWAP_WORDS);
  localparam int MF_W  = $clog2(MAIN_PAGES);
  localparam int SF_W  = $clog2(SWAP_PAGES);
  localparam int FR_W  = (MF_W > SF_W) ? MF_W : SF_W;
  localparam int MC_W  = $clog2(MAIN_PAGES + 1);
  localparam int SC_W  = $clog2(SWAP_PAGES + 1);
  localparam int SCN_W = (MC_W > SC_W) ? MC_W : SC_W;
  localparam int PID_W = $clog2(MAX_PIDS);
  localparam int NP_W  = $clog2(MAX_PIDS + 1);
  localparam int PC_W  = $clog2(MAX_PROC_PAGES + 1);
  localparam int FOP_D = MAX_PIDS * MAX_PROC_PAGES;
  localparam int FA_W  = $clog2(FOP_D);
  localparam int SP_W  = $clog2(FOP_D + 1);
  localparam int WO_W  = $clog2(PAGE_WORDS);
  localparam int CLR_N = (MAIN_WORDS > SWAP_WORDS) ? MAIN_WORDS : SWAP_WORDS;
  localparam int CLR_W = $clog2(CLR_N);

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_DECODE   = 5'd2;
  localparam logic [4:0] S_PG_TOP   = 5'd3;
  localparam logic [4:0] S_PG_FOP   = 5'd4;
  localparam logic [4:0] S_SCAN     = 5'd5;
  localparam logic [4:0] S_CP_RD    = 5'd6;
  localparam logic [4:0] S_CP_WR    = 5'd7;
  localparam logic [4:0] S_PG_END   = 5'd8;
  localparam logic [4:0] S_LR_SCAN  = 5'd9;
  localparam logic [4:0] S_LR_SHIFT = 5'd10;
  localparam logic [4:0] S_ACT_PUSH = 5'd11;
  localparam logic [4:0] S_SI_START = 5'd12;
  localparam logic [4:0] S_SI_WALK  = 5'd13;
  localparam logic [4:0] S_EVICT    = 5'd14;
  localparam logic [4:0] S_TR_CHK   = 5'd15;
  localparam logic [4:0] S_TR_DIV   = 5'd16;
  localparam logic [4:0] S_TR_FOP   = 5'd17;
  localparam logic [4:0] S_AC_OP    = 5'd18;
  localparam logic [4:0] S_AC_RDA   = 5'd19;
  localparam logic [4:0] S_AC_RDB   = 5'd20;
  localparam logic [4:0] S_AC_EXE   = 5'd21;
  localparam logic [4:0] S_PR_RD    = 5'd22;
  localparam logic [4:0] S_DONE     = 5'd23;

  localparam logic [2:0] PM_LOAD_MAIN = 3'd0;
  localparam logic [2:0] PM_LOAD_SWAP = 3'd1;
  localparam logic [2:0] PM_TO_SWAP   = 3'd2;
  localparam logic [2:0] PM_TO_MAIN   = 3'd3;
  localparam logic [2:0] PM_KILL      = 3'd4;

  function automatic logic [MC_W-1:0] eff_main_f(input logic [6:0] v);
    eff_main_f = (32'(v) > MAIN_PAGES) ? MC_W'(MAIN_PAGES) : MC_W'(v);
  endfunction

  function automatic logic [SC_W-1:0] eff_swap_f(input logic [7:0] v);
    eff_swap_f = (32'(v) > SWAP_PAGES) ? SC_W'(SWAP_PAGES) : SC_W'(v);
  endfunction

  logic [4:0]         state_r, ret_r;
  logic [6:0]         cfg_main_r;
  logic [7:0]         cfg_swap_r;
  logic [MC_W-1:0]    eff_main;
  logic [SC_W-1:0]    eff_swap;

  logic [3:0]         kind_r;
  logic [PID_W-1:0]   pid_r;
  logic [4:0]         size_r;
  logic [10:0]        a_r;
  logic [7:0]         b_r, c_r;
  logic [31:0]        val_r;
  logic [1:0]         place_r;

  logic [MAIN_PAGES-1:0] main_used_r;
  logic [SWAP_PAGES-1:0] swap_used_r;
  logic [PC_W-1:0]    proc_pages_r [MAX_PIDS];
  logic [1:0]         proc_place_r [MAX_PIDS];
  logic [PID_W-1:0]   lru_q_r [MAX_PIDS];
  logic [NP_W-1:0]    lru_len_r;
  logic [MC_W-1:0]    free_main_r;
  logic [SC_W-1:0]    free_swap_r;
  logic [NP_W-1:0]    next_pid_r;

  logic [2:0]         mode_r;
  logic [PID_W-1:0]   tgt_r;
  logic [PC_W-1:0]    pj_r, pn_r;
  logic [SCN_W-1:0]   scan_r;
  logic [FR_W-1:0]    f_r, dst_r;
  logic [WO_W-1:0]    k_r;
  logic [NP_W-1:0]    lk_r, sk_r;
  logic [SP_W-1:0]    space_r;
  logic [1:0]         ai_r;
  logic [10:0]        off_r;
  logic [PC_W-1:0]    tpg_r;
  logic [MWA-1:0]     pa_r, pb_r, pc_r;
  logic [31:0]        ra_r, rb_r;
  logic [CLR_W-1:0]   clr_r;

  logic [3:0]         st_r, asg_r;
  logic [31:0]        va_r, vb_r, vc_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic               main_we, swap_we, fop_we;
  logic [MWA-1:0]     main_waddr, main_raddr;
  logic [SWA-1:0]     swap_waddr, swap_raddr;
  logic [FA_W-1:0]    fop_waddr, fop_raddr;
  logic [31:0]        main_wdata, swap_wdata, main_rdata, swap_rdata;
  logic [FR_W-1:0]    fop_wdata, fop_rdata;

  logic               alu_sub;
  logic [31:0]        alu_a, alu_b, alu_y;

  logic               dst_main, is_load, scan_free, in_acc;
  logic [SCN_W-1:0]   scan_lim;
  logic [10:0]        cur_addr;
  logic [PC_W-1:0]    pid_pages, walk_pages, head_pages;
  logic [SP_W-1:0]    space_nxt;
  logic [MWA-1:0]     phys;

  assign eff_main  = eff_main_f(cfg_main_r);
  assign eff_swap  = eff_swap_f(cfg_swap_r);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign dst_main  = (mode_r == PM_LOAD_MAIN) || (mode_r == PM_TO_MAIN);
  assign is_load   = (mode_r == PM_LOAD_MAIN) || (mode_r == PM_LOAD_SWAP);
  assign scan_lim  = dst_main ? SCN_W'(eff_main) : SCN_W'(eff_swap);
  assign scan_free = dst_main ? !main_used_r[scan_r[MF_W-1:0]]
                              : !swap_used_r[scan_r[SF_W-1:0]];
  assign cur_addr  = (ai_r == 2'd0) ? a_r : (ai_r == 2'd1) ? 11'(b_r) : 11'(c_r);
  assign pid_pages  = proc_pages_r[pid_r];
  assign walk_pages = proc_pages_r[lru_q_r[sk_r[PID_W-1:0]]];
  assign head_pages = proc_pages_r[lru_q_r[0]];
  assign space_nxt  = space_r + SP_W'(walk_pages);
  assign phys = MWA'(32'(fop_rdata) * PAGE_WORDS + 32'(off_r));

  pmm_alu u_alu (
    .sub (alu_sub),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y)
  );

  always_comb begin
    if (state_r == S_AC_EXE) begin
      alu_sub = (kind_r == K_SUB);
      alu_a   = ra_r;
      alu_b   = rb_r;
    end else begin
      alu_sub = 1'b1;
      alu_a   = 32'(off_r);
      alu_b   = 32'(PAGE_WORDS);
    end
  end

  pmm_ram #(.DEPTH(MAIN_WORDS), .WIDTH(WORD_W)) u_main (
    .clk (clk), .we (main_we), .waddr (main_waddr), .wdata (main_wdata),
    .raddr (main_raddr), .rdata (main_rdata)
  );

  pmm_ram #(.DEPTH(SWAP_WORDS), .WIDTH(WORD_W)) u_swap (
    .clk (clk), .we (swap_we), .waddr (swap_waddr), .wdata (swap_wdata),
    .raddr (swap_raddr), .rdata (swap_rdata)
  );

  pmm_ram #(.DEPTH(FOP_D), .WIDTH(FR_W)) u_fop (
    .clk (clk), .we (fop_we), .waddr (fop_waddr), .wdata (fop_wdata),
    .raddr (fop_raddr), .rdata (fop_rdata)
  );

  always_comb begin
    main_we    = 1'b0;
    main_waddr = '0;
    main_wdata = '0;
    main_raddr = pa_r;
    swap_we    = 1'b0;
    swap_waddr = '0;
    swap_wdata = '0;
    swap_raddr = SWA'(32'(f_r) * PAGE_WORDS + 32'(k_r));
    fop_we     = 1'b0;
    fop_waddr  = FA_W'(32'(tgt_r) * MAX_PROC_PAGES + 32'(pj_r));
    fop_wdata  = dst_r;
    fop_raddr  = FA_W'(32'(tgt_r) * MAX_PROC_PAGES + 32'(pj_r));
    case (state_r)
      S_CLEAR: begin
        main_we    = (32'(clr_r) < MAIN_WORDS);
        main_waddr = MWA'(clr_r);
        swap_we    = (32'(clr_r) < SWAP_WORDS);
        swap_waddr = SWA'(clr_r);
      end
      S_DECODE: begin
        main_raddr = MWA'(a_r);
      end
      S_TR_DIV: begin
        fop_raddr = FA_W'(32'(pid_r) * MAX_PROC_PAGES + 32'(tpg_r));
      end
      S_SCAN: begin
        fop_we    = is_load && (scan_r < scan_lim) && scan_free;
        fop_wdata = FR_W'(scan_r);
      end
      S_CP_RD: begin
        main_raddr = MWA'(32'(f_r) * PAGE_WORDS + 32'(k_r));
      end
      S_CP_WR: begin
        fop_we = (32'(k_r) == PAGE_WORDS - 1);
        if (mode_r == PM_TO_SWAP) begin
          swap_we    = 1'b1;
          swap_waddr = SWA'(32'(dst_r) * PAGE_WORDS + 32'(k_r));
          swap_wdata = main_rdata;
          main_we    = 1'b1;
          main_waddr = MWA'(32'(f_r) * PAGE_WORDS + 32'(k_r));
        end else begin
          main_we    = 1'b1;
          main_waddr = MWA'(32'(dst_r) * PAGE_WORDS + 32'(k_r));
          main_wdata = swap_rdata;
          swap_we    = 1'b1;
          swap_waddr = SWA'(32'(f_r) * PAGE_WORDS + 32'(k_r));
        end
      end
      S_AC_OP: begin
        main_raddr = pa_r;
        main_we    = (kind_r == K_STORE);
        main_waddr = pa_r;
        main_wdata = val_r;
      end
      S_AC_RDA: begin
        main_raddr = pb_r;
      end
      S_AC_EXE: begin
        main_we    = 1'b1;
        main_waddr = pc_r;
        main_wdata = alu_y;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ret_r       <= S_DONE;
      cfg_main_r  <= MAIN_IN_USE_RST;
      cfg_swap_r  <= SWAP_IN_USE_RST;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      main_used_r <= '0;
      swap_used_r <= '0;
      for (int i = 0; i < MAX_PIDS; i++) begin
        proc_pages_r[i] <= '0;
        proc_place_r[i] <= AT_NONE;
      end
      lru_len_r   <= '0;
      free_main_r <= eff_main_f(MAIN_IN_USE_RST);
      free_swap_r <= eff_swap_f(SWAP_IN_USE_RST);
      next_pid_r  <= NP_W'(1);
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == CLR_N - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            kind_r  <= in_tuser;
            pid_r   <= PID_W'(in_tdata[3:0]);
            size_r  <= in_tdata[8:4];
            a_r     <= in_tdata[19:9];
            b_r     <= in_tdata[27:20];
            c_r     <= in_tdata[35:28];
            val_r   <= in_tdata[67:36];
            place_r <= (32'(in_tdata[3:0]) < MAX_PIDS) ?
                       proc_place_r[PID_W'(in_tdata[3:0])] : AT_NONE;
            st_r    <= ST_OK;
            asg_r   <= '0;
            va_r    <= '0;
            vb_r    <= '0;
            vc_r    <= '0;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          pj_r    <= '0;
          scan_r  <= '0;
          lk_r    <= '0;
          ai_r    <= '0;
          tgt_r   <= pid_r;
          pn_r    <= pid_pages;
          ret_r   <= S_DONE;
          state_r <= S_DONE;
          case (kind_r)
            K_LOAD: begin
              tgt_r <= next_pid_r[PID_W-1:0];
              pn_r  <= PC_W'(size_r);
              if (32'(next_pid_r) >= MAX_PIDS) begin
                st_r <= ST_PIDS_OUT;
              end else if (32'(size_r) > MAX_PROC_PAGES) begin
                st_r <= ST_FULL;
              end else if (32'(size_r) <= 32'(free_main_r)) begin
                mode_r  <= PM_LOAD_MAIN;
                state_r <= S_PG_TOP;
              end else if (32'(size_r) > 32'(free_swap_r)) begin
                st_r <= ST_FULL;
              end else begin
                mode_r  <= PM_LOAD_SWAP;
                state_r <= S_PG_TOP;
              end
            end
            K_ACTIVATE, K_SWAPIN: begin
              if (place_r == AT_NONE) begin
                st_r <= ST_NO_PROC;
              end else if (place_r == AT_MAIN) begin
                if (kind_r == K_SWAPIN) begin
                  st_r <= ST_ALREADY;
                end else begin
                  ret_r   <= S_ACT_PUSH;
                  state_r <= S_LR_SCAN;
                end
              end else begin
                state_r <= S_SI_START;
              end
            end
            K_STORE, K_READ, K_ADD, K_SUB: begin
              if (place_r != AT_MAIN) begin
                st_r <= ST_NO_PROC;
              end else begin
                state_r <= S_TR_CHK;
              end
            end
            K_KILL: begin
              if (place_r == AT_NONE) begin
                st_r <= ST_NO_PROC;
              end else begin
                mode_r  <= PM_KILL;
                state_r <= S_PG_TOP;
              end
            end
            K_SWAPOUT: begin
              if (place_r == AT_NONE) begin
                st_r <= ST_NO_PROC;
              end else if (place_r == AT_MAIN) begin
                if (32'(pid_pages) > 32'(free_swap_r)) begin
                  st_r <= ST_NO_SWAP;
                end else begin
                  mode_r  <= PM_TO_SWAP;
                  state_r <= S_PG_TOP;
                end
              end
            end
            K_PHYSREAD: begin
              if ((32'(a_r) >= 32'(eff_main) * PAGE_WORDS) || (32'(a_r) >= MAIN_WORDS)) begin
                st_r <= ST_PHYS_BOUNDS;
              end else begin
                state_r <= S_PR_RD;
              end
            end
            default: begin
            end
          endcase
        end
        S_PG_TOP: begin
          if (pj_r == pn_r) begin
            state_r <= S_PG_END;
          end else if (is_load) begin
            state_r <= S_SCAN;
          end else begin
            state_r <= S_PG_FOP;
          end
        end
        S_PG_FOP: begin
          f_r <= fop_rdata;
          if (mode_r == PM_KILL) begin
            if (place_r == AT_MAIN && 32'(fop_rdata) < MAIN_PAGES) begin
              main_used_r[fop_rdata[MF_W-1:0]] <= 1'b0;
            end
            if (place_r == AT_SWAP && 32'(fop_rdata) < SWAP_PAGES) begin
              swap_used_r[fop_rdata[SF_W-1:0]] <= 1'b0;
            end
            pj_r    <= pj_r + 1'b1;
            state_r <= S_PG_TOP;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_r <= scan_r + 1'b1;
          if (scan_r >= scan_lim) begin
            state_r <= S_PG_END;
          end else if (scan_free) begin
            if (dst_main) begin
              main_used_r[scan_r[MF_W-1:0]] <= 1'b1;
            end else begin
              swap_used_r[scan_r[SF_W-1:0]] <= 1'b1;
            end
            dst_r <= FR_W'(scan_r);
            k_r   <= '0;
            if (is_load) begin
              pj_r    <= pj_r + 1'b1;
              state_r <= S_PG_TOP;
            end else begin
              state_r <= S_CP_RD;
            end
          end
        end
        S_CP_RD: begin
          state_r <= S_CP_WR;
        end
        S_CP_WR: begin
          if (32'(k_r) == PAGE_WORDS - 1) begin
            if (mode_r == PM_TO_SWAP) begin
              main_used_r[f_r[MF_W-1:0]] <= 1'b0;
            end else begin
              swap_used_r[f_r[SF_W-1:0]] <= 1'b0;
            end
            pj_r    <= pj_r + 1'b1;
            state_r <= S_PG_TOP;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_CP_RD;
          end
        end
        S_PG_END: begin
          lk_r    <= '0;
          state_r <= S_DONE;
          case (mode_r)
            PM_LOAD_MAIN, PM_LOAD_SWAP: begin
              proc_pages_r[tgt_r] <= pn_r;
              next_pid_r <= next_pid_r + 1'b1;
              asg_r      <= 4'(tgt_r);
              if (mode_r == PM_LOAD_MAIN) begin
                proc_place_r[tgt_r] <= AT_MAIN;
                free_main_r <= free_main_r - MC_W'(pn_r);
                st_r        <= ST_LOAD_MAIN;
                if (32'(lru_len_r) < MAX_PIDS) begin
                  lru_q_r[lru_len_r[PID_W-1:0]] <= tgt_r;
                  lru_len_r <= lru_len_r + 1'b1;
                end
              end else begin
                proc_place_r[tgt_r] <= AT_SWAP;
                free_swap_r <= free_swap_r - SC_W'(pn_r);
                st_r        <= ST_LOAD_SWAP;
              end
            end
            PM_TO_SWAP: begin
              free_main_r <= free_main_r + MC_W'(pn_r);
              free_swap_r <= free_swap_r - SC_W'(pn_r);
              proc_place_r[tgt_r] <= AT_SWAP;
              state_r <= S_LR_SCAN;
            end
            PM_TO_MAIN: begin
              free_main_r <= free_main_r - MC_W'(pn_r);
              free_swap_r <= free_swap_r + SC_W'(pn_r);
              proc_place_r[tgt_r] <= AT_MAIN;
              if (32'(lru_len_r) < MAX_PIDS) begin
                lru_q_r[lru_len_r[PID_W-1:0]] <= tgt_r;
                lru_len_r <= lru_len_r + 1'b1;
              end
            end
            PM_KILL: begin
              proc_place_r[tgt_r] <= AT_NONE;
              if (place_r == AT_MAIN) begin
                free_main_r <= free_main_r + MC_W'(pn_r);
                st_r        <= ST_KILL_MAIN;
                ret_r       <= S_DONE;
                state_r     <= S_LR_SCAN;
              end else begin
                free_swap_r <= free_swap_r + SC_W'(pn_r);
                st_r        <= ST_KILL_SWAP;
              end
            end
            default: begin
            end
          endcase
        end
        S_LR_SCAN: begin
          if ((lk_r >= lru_len_r) || (32'(lk_r) >= MAX_PIDS)) begin
            state_r <= ret_r;
          end else if (lru_q_r[lk_r[PID_W-1:0]] == tgt_r) begin
            state_r <= S_LR_SHIFT;
          end else begin
            lk_r <= lk_r + 1'b1;
          end
        end
        S_LR_SHIFT: begin
          for (int i = 0; i < MAX_PIDS - 1; i++) begin
            if (i >= 32'(lk_r)) begin
              lru_q_r[i] <= lru_q_r[i+1];
            end
          end
          lru_len_r <= lru_len_r - 1'b1;
          state_r   <= ret_r;
        end
        S_ACT_PUSH: begin
          if (32'(lru_len_r) < MAX_PIDS) begin
            lru_q_r[lru_len_r[PID_W-1:0]] <= tgt_r;
            lru_len_r <= lru_len_r + 1'b1;
          end
          state_r <= S_DONE;
        end
        S_SI_START: begin
          space_r <= '0;
          sk_r    <= '0;
          if (32'(pid_pages) <= 32'(free_main_r)) begin
            state_r <= S_EVICT;
          end else if (32'(pid_pages) > 32'(eff_main)) begin
            st_r    <= ST_LRU_BIG;
            state_r <= S_DONE;
          end else begin
            state_r <= S_SI_WALK;
          end
        end
        S_SI_WALK: begin
          if ((sk_r >= lru_len_r) || (32'(sk_r) >= MAX_PIDS)) begin
            st_r    <= ST_LRU_SHORT;
            state_r <= S_DONE;
          end else if (32'(space_nxt) + 32'(free_main_r) >= 32'(pid_pages)) begin
            if (32'(space_nxt) > 32'(free_swap_r)) begin
              st_r    <= ST_LRU_SWAP;
              state_r <= S_DONE;
            end else begin
              state_r <= S_EVICT;
            end
          end else begin
            space_r <= space_nxt;
            sk_r    <= sk_r + 1'b1;
          end
        end
        S_EVICT: begin
          pj_r    <= '0;
          scan_r  <= '0;
          state_r <= S_PG_TOP;
          if ((32'(free_main_r) < 32'(pid_pages)) && (lru_len_r != '0)) begin
            mode_r <= PM_TO_SWAP;
            tgt_r  <= lru_q_r[0];
            pn_r   <= head_pages;
            ret_r  <= S_EVICT;
          end else begin
            mode_r <= PM_TO_MAIN;
            tgt_r  <= pid_r;
            pn_r   <= pid_pages;
          end
        end
        S_TR_CHK: begin
          if (32'(cur_addr) >= 32'(pid_pages) * PAGE_WORDS) begin
            st_r    <= ST_BAD_ADDR;
            state_r <= S_DONE;
          end else begin
            off_r   <= cur_addr;
            tpg_r   <= '0;
            state_r <= S_TR_DIV;
          end
        end
        S_TR_DIV: begin
          if (32'(off_r) >= PAGE_WORDS) begin
            off_r <= alu_y[10:0];
            tpg_r <= tpg_r + 1'b1;
          end else begin
            state_r <= S_TR_FOP;
          end
        end
        S_TR_FOP: begin
          case (ai_r)
            2'd0:    pa_r <= phys;
            2'd1:    pb_r <= phys;
            default: pc_r <= phys;
          endcase
          if ((ai_r == 2'd2) || (kind_r == K_STORE) || (kind_r == K_READ)) begin
            state_r <= S_AC_OP;
          end else begin
            ai_r    <= ai_r + 1'b1;
            state_r <= S_TR_CHK;
          end
        end
        S_AC_OP: begin
          if (kind_r == K_STORE) begin
            va_r    <= val_r;
            state_r <= S_DONE;
          end else begin
            state_r <= S_AC_RDA;
          end
        end
        S_AC_RDA: begin
          ra_r <= main_rdata;
          if (kind_r == K_READ) begin
            va_r    <= main_rdata;
            state_r <= S_DONE;
          end else begin
            state_r <= S_AC_RDB;
          end
        end
        S_AC_RDB: begin
          rb_r    <= main_rdata;
          state_r <= S_AC_EXE;
        end
        S_AC_EXE: begin
          va_r    <= (pa_r == pc_r) ? alu_y : ra_r;
          vb_r    <= (pb_r == pc_r) ? alu_y : rb_r;
          vc_r    <= alu_y;
          state_r <= S_DONE;
        end
        S_PR_RD: begin
          va_r    <= main_rdata;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {vc_r, vb_r, va_r, asg_r, st_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cfg_we && (cfg_addr == REG_MAIN_PAGES || cfg_addr == REG_SWAP_PAGES)) begin
        if (cfg_addr == REG_MAIN_PAGES) begin
          cfg_main_r  <= cfg_wdata[6:0];
          free_main_r <= eff_main_f(cfg_wdata[6:0]);
          free_swap_r <= eff_swap;
        end else begin
          cfg_swap_r  <= cfg_wdata;
          free_main_r <= eff_main;
          free_swap_r <= eff_swap_f(cfg_wdata);
        end
        main_used_r <= '0;
        swap_used_r <= '0;
        for (int i = 0; i < MAX_PIDS; i++) begin
          proc_pages_r[i] <= '0;
          proc_place_r[i] <= AT_NONE;
        end
        lru_len_r  <= '0;
        next_pid_r <= NP_W'(1);
        clr_r      <= '0;
        state_r    <= S_CLEAR;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/pmm_checker.sv]
// ----------------------------------------------------------------------------
// pmm_checker
// port-level checks of the paged memory manager, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pmm_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [pmm_pkg::IN_DATA_W-1:0]  in_tdata,
  input wire logic [pmm_pkg::KIND_W-1:0]     in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [pmm_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           cfg_we,
  input wire logic [pmm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input wire logic [pmm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import pmm_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_tvalid, in_tdata, in_tuser, cfg_addr, cfg_wdata};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] <= ST_PHYS_BOUNDS))
    else $error("status code out of range");

  a_pid_only_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:0] != ST_LOAD_MAIN) && (out_tdata[3:0] != ST_LOAD_SWAP)
      |-> (out_tdata[7:4] == 4'd0))
    else $error("process number given without a load");

  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("transaction taken during clearing pass");

endmodule

bind paged_memory_manager_lru_swap pmm_checker u_pmm_checker (.*);

`default_nettype wire
